// ----- rtl/core/krt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the keyed record table.
// Depends on nothing; every other file of the block but krt_ram imports it.
package krt_pkg;

  // Default capacity of the table in records.
  localparam int unsigned KRT_MAX_ENTRIES = 16;

  // Largest grade that is stored; larger inputs saturate to it.
  localparam logic [6:0] GRADE_MAX = 7'd100;

  // Operation codes carried in the op field of an input beat.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DUP       = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT,
    ST_LIST
  } state_t;

  // Input beat payload.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] record_key;
    logic [7:0]  year_in;
    logic [31:0] course_a_id_in;
    logic [6:0]  course_a_grade_in;
    logic [31:0] course_b_id_in;
    logic [6:0]  course_b_grade_in;
    logic [31:0] course_c_id_in;
    logic [6:0]  course_c_grade_in;
  } in_t;

  // Result beat payload.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key_out;
    logic [7:0]  year_out;
    logic [31:0] course_a_id_out;
    logic [6:0]  course_a_grade_out;
    logic [31:0] course_b_id_out;
    logic [6:0]  course_b_grade_out;
    logic [31:0] course_c_id_out;
    logic [6:0]  course_c_grade_out;
    logic [4:0]  used_entries;
    logic        table_full;
    logic        last_of_run;
  } out_t;

  // One stored record, as kept in the record memory.
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  year;
    logic [31:0] course_a_id;
    logic [6:0]  course_a_grade;
    logic [31:0] course_b_id;
    logic [6:0]  course_b_grade;
    logic [31:0] course_c_id;
    logic [6:0]  course_c_grade;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;       // capture the request, rewind the scan
    logic    step;         // read the next entry if one is left
    logic    shift_start;  // restart the scan just past the hit
    logic    shift_wr;     // move the last entry read down by one place
    logic    add_wr;       // append the request and count it
    logic    cnt_dec;      // one record fewer
    logic    set_res;      // latch the pending result status
    status_t res_status;
    logic    res_data;     // pending result carries the record read
    logic    load_res;     // put the pending result into the output register
    logic    load_list;    // put the listed key into the output register
  } krt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;         // operation of the captured request
    logic pvalid;     // read data holds an entry
    logic key_match;  // that entry carries the requested key
    logic more;       // entries remain to be read
    logic full;
    logic empty;
    logic out_free;   // output register can take a beat this cycle
    logic list_last;  // entry in the read data is the last stored one
  } krt_stat_t;

  // Saturate a grade to the allowed maximum.
  function automatic logic [6:0] sat_grade(input logic [6:0] g);
    return (g > GRADE_MAX) ? GRADE_MAX : g;
  endfunction

endpackage

// ----- rtl/core/keyed_record_table_top.sv -----
`timescale 1ns / 1ps
// Top level of the keyed record table: controller, datapath and record memory.
// Uses krt_pkg, krt_ctrl and krt_dp.
//
// The table holds up to MAX_ENTRIES records in one memory with a single read
// and a single write port, packed in insertion order, and works on one
// request at a time. Add, read and delete search one entry per cycle; a
// delete then moves every later record down one place, one per cycle. A
// list gives one key beat per cycle while the consumer takes them. A
// finished result waits in the output register, and the next request is
// taken while it waits. The memory needs no clearing after reset; only
// entries below the count are ever read.
module keyed_record_table_top #(
  parameter int unsigned MAX_ENTRIES = krt_pkg::KRT_MAX_ENTRIES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  krt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output krt_pkg::out_t out_data
);
  import krt_pkg::*;

  krt_cmd_t  cmd;
  krt_stat_t stat;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  krt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/krt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/krt_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the keyed record table: request register, scan counters,
// record memory, entry count and output register. Uses krt_pkg and krt_ram.
module krt_dp #(
  parameter int unsigned MAX_ENTRIES = krt_pkg::KRT_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  krt_pkg::in_t        in_data,
  input  krt_pkg::krt_cmd_t   cmd,
  output krt_pkg::krt_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output krt_pkg::out_t       out_data
);
  import krt_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned RW = $bits(rec_t);

  in_t           req_r, req_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          pvalid_r, pvalid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  status_t       res_status_r, res_status_nxt;
  logic          res_data_r, res_data_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic          more;
  logic          out_free;
  logic          list_last;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata, ram_rdata, add_rec;
  logic [RW-1:0] ram_rdata_raw;

  assign more      = (idx_r < count_r);
  assign out_free  = !out_valid_r || out_ready;
  assign list_last = ((CW'(pidx_r) + CW'(1)) == count_r);

  // Record built from the captured request.
  always_comb begin
    add_rec.key            = req_r.record_key;
    add_rec.year           = req_r.year_in;
    add_rec.course_a_id    = req_r.course_a_id_in;
    add_rec.course_a_grade = req_r.course_a_grade_in;
    add_rec.course_b_id    = req_r.course_b_id_in;
    add_rec.course_b_grade = req_r.course_b_grade_in;
    add_rec.course_c_id    = req_r.course_c_id_in;
    add_rec.course_c_grade = req_r.course_c_grade_in;
  end

  // Memory port control: appends go to the end, shifts one place down.
  assign ram_re    = cmd.step && more;
  assign ram_we    = cmd.add_wr || cmd.shift_wr;
  assign ram_waddr = cmd.add_wr ? count_r[AW-1:0] : (pidx_r - AW'(1));
  assign ram_wdata = cmd.add_wr ? add_rec : ram_rdata;
  assign ram_rdata = rec_t'(ram_rdata_raw);

  krt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ENTRIES)
  ) u_rec_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (RW'(ram_wdata)),
    .re      (ram_re),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (ram_rdata_raw)
  );

  // Request capture with grade saturation.
  always_comb begin
    req_nxt = req_r;
    if (cmd.accept) begin
      req_nxt                   = in_data;
      req_nxt.course_a_grade_in = sat_grade(in_data.course_a_grade_in);
      req_nxt.course_b_grade_in = sat_grade(in_data.course_b_grade_in);
      req_nxt.course_c_grade_in = sat_grade(in_data.course_c_grade_in);
    end
  end

  // Scan pointer: idx is the next entry to read, pidx the entry in the read data.
  always_comb begin
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pvalid_nxt = pvalid_r;
    if (cmd.accept) begin
      idx_nxt    = '0;
      pvalid_nxt = 1'b0;
    end else if (cmd.shift_start) begin
      idx_nxt    = CW'(pidx_r) + CW'(1);
      pvalid_nxt = 1'b0;
    end else if (cmd.step) begin
      if (more) begin
        idx_nxt    = idx_r + CW'(1);
        pidx_nxt   = idx_r[AW-1:0];
        pvalid_nxt = 1'b1;
      end else begin
        pvalid_nxt = 1'b0;
      end
    end
  end

  // Entry count.
  always_comb begin
    count_nxt = count_r;
    if (cmd.add_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Pending result.
  always_comb begin
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    if (cmd.set_res) begin
      res_status_nxt = cmd.res_status;
      res_data_nxt   = cmd.res_data;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cmd.load_res || cmd.load_list) begin
      out_valid_nxt        = 1'b1;
      out_nxt              = '0;
      out_nxt.used_entries = 5'(count_r);
      out_nxt.table_full   = (count_r == CW'(MAX_ENTRIES));
      if (cmd.load_list) begin
        out_nxt.status      = STAT_OK;
        out_nxt.key_out     = ram_rdata.key;
        out_nxt.last_of_run = list_last;
      end else begin
        out_nxt.status      = res_status_r;
        out_nxt.last_of_run = 1'b1;
        if (res_data_r) begin
          out_nxt.key_out            = ram_rdata.key;
          out_nxt.year_out           = ram_rdata.year;
          out_nxt.course_a_id_out    = ram_rdata.course_a_id;
          out_nxt.course_a_grade_out = ram_rdata.course_a_grade;
          out_nxt.course_b_id_out    = ram_rdata.course_b_id;
          out_nxt.course_b_grade_out = ram_rdata.course_b_grade;
          out_nxt.course_c_id_out    = ram_rdata.course_c_id;
          out_nxt.course_c_grade_out = ram_rdata.course_c_grade;
        end
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pvalid_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      pvalid_r    <= pvalid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    pidx_r       <= pidx_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_r        <= out_nxt;
  end

  // Status toward the controller.
  always_comb begin
    stat.op        = op_t'(req_r.op);
    stat.pvalid    = pvalid_r;
    stat.key_match = pvalid_r && (ram_rdata.key == req_r.record_key);
    stat.more      = more;
    stat.full      = (count_r == CW'(MAX_ENTRIES));
    stat.empty     = (count_r == '0);
    stat.out_free  = out_free;
    stat.list_last = list_last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/krt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the keyed record table: sequences search, shift, append,
// list and result beats. Uses krt_pkg; drives krt_dp through commands.
module krt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  krt_pkg::krt_stat_t stat,
  output krt_pkg::krt_cmd_t  cmd
);
  import krt_pkg::*;

  state_t state_r, state_nxt;
  logic   scan_miss;
  logic   shift_done;

  assign scan_miss  = !stat.pvalid && !stat.more;
  assign shift_done = !stat.pvalid && !stat.more;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_ADD:  state_nxt = stat.full ? ST_EMIT : ST_SCAN;
          OP_LIST: state_nxt = stat.empty ? ST_EMIT : ST_LIST;
          default: state_nxt = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        if (stat.key_match) begin
          state_nxt = (stat.op == OP_DELETE) ? ST_SHIFT : ST_EMIT;
        end else if (scan_miss) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        if (shift_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_LIST: begin
        if (stat.pvalid && stat.out_free && stat.list_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd            = '0;
    cmd.res_status = STAT_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DISPATCH: begin
        if (stat.op == OP_ADD && stat.full) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = STAT_FULL;
        end else if (stat.op == OP_LIST && stat.empty) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = STAT_EMPTY;
        end
      end
      ST_SCAN: begin
        if (stat.key_match) begin
          case (stat.op)
            OP_ADD: begin
              cmd.set_res    = 1'b1;
              cmd.res_status = STAT_DUP;
            end
            OP_READ: begin
              cmd.set_res    = 1'b1;
              cmd.res_status = STAT_OK;
              cmd.res_data   = 1'b1;
            end
            default: cmd.shift_start = 1'b1;
          endcase
        end else if (scan_miss) begin
          cmd.set_res = 1'b1;
          if (stat.op == OP_ADD) begin
            cmd.add_wr     = 1'b1;
            cmd.res_status = STAT_OK;
          end else begin
            cmd.res_status = STAT_NOT_FOUND;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (shift_done) begin
          cmd.cnt_dec    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = STAT_OK;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = stat.pvalid;
        end
      end
      ST_EMIT: begin
        cmd.load_res = stat.out_free;
      end
      ST_LIST: begin
        if (stat.pvalid) begin
          if (stat.out_free) begin
            cmd.load_list = 1'b1;
            cmd.step      = !stat.list_last;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
